// ===== design/bspa_pkg.sv =====
// Shared types, codes and field widths of the baseline-subtracted pulse averager.
`timescale 1ns / 1ps

package bspa_pkg;

   // Field widths of the request, result and register beats.
   localparam int KIND_W     = 2;
   localparam int SAMPLE_W   = 14;
   localparam int BIN_W      = 12;
   localparam int LEN_CFG_W  = 13;
   localparam int BSUM_W     = 23;
   localparam int VAR_W      = 44;
   localparam int BINSUM_W   = 40;
   localparam int COUNT_W    = 16;
   localparam int ACC_W      = 41;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 128;
   localparam int RSP_PAD_W  = RSP_DATA_W - (BSUM_W + 1 + VAR_W + BINSUM_W + COUNT_W);

   localparam logic [LEN_CFG_W-1:0] LEN_RESET = 13'd4096;
   localparam logic [BSUM_W-1:0]    BSUM_MAX  = {BSUM_W{1'b1}};
   localparam logic [VAR_W-1:0]     VAR_MAX   = {VAR_W{1'b1}};
   localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Result kinds.
   localparam logic RKIND_REPORT = 1'b0;
   localparam logic RKIND_READ   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SAMPLE,
      ST_VAR_MUL,
      ST_VAR_SUB,
      ST_VAR_SEL,
      ST_ACCUM,
      ST_DRAIN,
      ST_REPORT,
      ST_READ,
      ST_READ_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic sample_update;
      logic var_mul;
      logic var_sub;
      logic var_sel;
      logic clear_step;
      logic accum_step;
      logic count_bump;
      logic load_report;
      logic load_read;
   } cmd_type;

   typedef struct packed {
      logic wave_last;
      logic clear_last;
      logic accum_last;
      logic count_full;
      logic out_free;
   } status_type;

endpackage

// ===== design/bspa_ctrl.sv =====
// Sequencer of the averager: decodes request beats and steps the datapath.
`timescale 1ns / 1ps

module bspa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [bspa_pkg::KIND_W-1:0]   req_kind,
   input  bspa_pkg::status_type          status,
   output logic                          req_tready,
   output bspa_pkg::cmd_type             cmd
);

   bspa_pkg::state_type state_ff;
   bspa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bspa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bspa_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = bspa_pkg::ST_IDLE;
            end
         end
         bspa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (req_kind)
                  bspa_pkg::KIND_SAMPLE: state_in = bspa_pkg::ST_SAMPLE;
                  bspa_pkg::KIND_READ:   state_in = bspa_pkg::ST_READ;
                  bspa_pkg::KIND_CLEAR:  state_in = bspa_pkg::ST_CLEAR;
                  default:               state_in = bspa_pkg::ST_IDLE;
               endcase
            end
         end
         bspa_pkg::ST_SAMPLE: begin
            state_in = status.wave_last ? bspa_pkg::ST_VAR_MUL : bspa_pkg::ST_IDLE;
         end
         bspa_pkg::ST_VAR_MUL: state_in = bspa_pkg::ST_VAR_SUB;
         bspa_pkg::ST_VAR_SUB: state_in = bspa_pkg::ST_VAR_SEL;
         bspa_pkg::ST_VAR_SEL: begin
            // A saturated count skips the accumulate sweep but still reports.
            state_in = status.count_full ? bspa_pkg::ST_REPORT : bspa_pkg::ST_ACCUM;
         end
         bspa_pkg::ST_ACCUM: begin
            if (status.accum_last) begin
               state_in = bspa_pkg::ST_DRAIN;
            end
         end
         bspa_pkg::ST_DRAIN: state_in = bspa_pkg::ST_REPORT;
         bspa_pkg::ST_REPORT: begin
            if (status.out_free) begin
               state_in = bspa_pkg::ST_IDLE;
            end
         end
         bspa_pkg::ST_READ: state_in = bspa_pkg::ST_READ_OUT;
         bspa_pkg::ST_READ_OUT: begin
            if (status.out_free) begin
               state_in = bspa_pkg::ST_IDLE;
            end
         end
         default: state_in = bspa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         bspa_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         bspa_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         bspa_pkg::ST_SAMPLE:  cmd.sample_update = 1'b1;
         bspa_pkg::ST_VAR_MUL: cmd.var_mul = 1'b1;
         bspa_pkg::ST_VAR_SUB: cmd.var_sub = 1'b1;
         bspa_pkg::ST_VAR_SEL: cmd.var_sel = 1'b1;
         bspa_pkg::ST_ACCUM:   cmd.accum_step = 1'b1;
         bspa_pkg::ST_DRAIN:   cmd.count_bump = 1'b1;
         bspa_pkg::ST_REPORT:  cmd.load_report = status.out_free;
         bspa_pkg::ST_READ:    cmd = '0;
         bspa_pkg::ST_READ_OUT: cmd.load_read = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== design/bspa_datapath.sv =====
// Datapath of the averager: window sums, variance select, buffers and result register.
`timescale 1ns / 1ps

module bspa_datapath #(
   parameter int BASE_LEN    = 512,
   parameter int WAVE_MAX    = 4096,
   parameter int SAMPLE_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bspa_pkg::cmd_type                 cmd,
   output bspa_pkg::status_type              status,
   input  logic [bspa_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic [bspa_pkg::BIN_W-1:0]        req_bin,
   input  logic                              csr_write,
   input  logic [bspa_pkg::LEN_CFG_W-1:0]    csr_wdata,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [bspa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int ADDR_W  = $clog2(WAVE_MAX);
   localparam int LEN_W   = $clog2(WAVE_MAX + 1);
   localparam int BL_W    = $clog2(BASE_LEN + 1);
   localparam int SUM_W   = SAMPLE_BITS + BL_W;
   localparam int SQ1_W   = 2 * SAMPLE_BITS;
   localparam int SQ_W    = SQ1_W + BL_W;
   localparam int PROD_W  = 2 * SUM_W;
   localparam int SCL_W   = SAMPLE_BITS + BL_W;
   localparam int EXT_W   = (LEN_W > bspa_pkg::LEN_CFG_W) ? LEN_W : bspa_pkg::LEN_CFG_W;
   localparam int BIN_EXT = (LEN_W > bspa_pkg::BIN_W) ? LEN_W : bspa_pkg::BIN_W;
   localparam int BS_EXT  = (SUM_W > bspa_pkg::BSUM_W) ? SUM_W : bspa_pkg::BSUM_W;
   localparam int VR_EXT  = (PROD_W > bspa_pkg::VAR_W) ? PROD_W : bspa_pkg::VAR_W;
   localparam int ACC_W   = bspa_pkg::ACC_W;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [bspa_pkg::LEN_CFG_W-1:0] raw);
      logic [EXT_W-1:0] v;
      v = EXT_W'(raw);
      if (v < EXT_W'(BASE_LEN)) begin
         v = EXT_W'(BASE_LEN);
      end else if (v > EXT_W'(WAVE_MAX)) begin
         v = EXT_W'(WAVE_MAX);
      end
      return LEN_W'(v);
   endfunction

   logic [LEN_W-1:0]        eff_len_ff;
   logic [LEN_W-1:0]        pos_ff;
   logic [SUM_W-1:0]        head_sum_ff, tail_sum_ff;
   logic [SQ_W-1:0]         head_sq_ff, tail_sq_ff;
   logic [SAMPLE_BITS-1:0]  sample_ff;
   logic [ADDR_W-1:0]       bin_addr_ff;
   logic                    bin_ok_ff;
   logic [PROD_W-1:0]       head_a_ff, head_b_ff, tail_a_ff, tail_b_ff;
   logic [PROD_W-1:0]       head_var_ff, tail_var_ff;
   logic [SUM_W-1:0]        wsum_ff;
   logic [PROD_W-1:0]       wvar_ff;
   logic                    used_tail_ff;
   logic [ADDR_W-1:0]       sweep_ff;
   logic                    pend_ff;
   logic [ADDR_W-1:0]       pend_addr_ff;
   logic [ACC_W-1:0]        acc_rd_ff;
   logic [SAMPLE_BITS-1:0]  buf_rd_ff;
   logic [bspa_pkg::COUNT_W-1:0]    waves_ff;
   logic                            rsp_valid_ff;
   logic [bspa_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                            rsp_user_ff;

   logic [SAMPLE_BITS-1:0]  buf_mem_ff [WAVE_MAX];
   logic [ACC_W-1:0]        acc_mem_ff [WAVE_MAX];

   logic [SQ1_W-1:0]        sample_sq;
   logic                    in_head, in_tail;
   logic [LEN_W-1:0]        pos_in;
   logic                    sweep_last;
   logic                    tail_pick;
   logic [SCL_W-1:0]        scaled;
   logic [ACC_W-1:0]        acc_sum;
   logic                    acc_we;
   logic [ADDR_W-1:0]       acc_waddr, acc_raddr;
   logic [ACC_W-1:0]        acc_wdata;
   logic [BS_EXT-1:0]       bsum_ext;
   logic [VR_EXT-1:0]       var_ext;
   logic [bspa_pkg::BSUM_W-1:0]     bsum_sat;
   logic [bspa_pkg::VAR_W-1:0]      var_sat;
   logic [bspa_pkg::BINSUM_W-1:0]   bin_sum;
   logic [bspa_pkg::RSP_DATA_W-1:0] report_data, read_data;

   // Window membership and end of waveform, from the position before this sample.
   assign sample_sq = SQ1_W'(sample_ff) * SQ1_W'(sample_ff);
   assign in_head   = pos_ff < LEN_W'(BASE_LEN);
   assign in_tail   = pos_ff >= (eff_len_ff - LEN_W'(BASE_LEN));
   assign pos_in    = pos_ff + LEN_W'(1);

   assign status.wave_last  = (pos_in == eff_len_ff);
   assign status.clear_last = (sweep_ff == ADDR_W'(WAVE_MAX - 1));
   assign status.accum_last = (LEN_W'(sweep_ff) == (eff_len_ff - LEN_W'(1)));
   assign status.count_full = (waves_ff == bspa_pkg::COUNT_MAX);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign sweep_last = cmd.clear_step ? status.clear_last : status.accum_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_len_ff <= clamp_len(bspa_pkg::LEN_RESET);
      end else if (csr_write) begin
         eff_len_ff <= clamp_len(csr_wdata);
      end
   end

   // A length write drops the partly received waveform.
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         pos_ff      <= '0;
         head_sum_ff <= '0;
         head_sq_ff  <= '0;
         tail_sum_ff <= '0;
         tail_sq_ff  <= '0;
      end else if (cmd.sample_update) begin
         pos_ff <= status.wave_last ? LEN_W'(0) : pos_in;
         if (in_head) begin
            head_sum_ff <= head_sum_ff + SUM_W'(sample_ff);
            head_sq_ff  <= head_sq_ff + SQ_W'(sample_sq);
         end
         if (in_tail) begin
            tail_sum_ff <= tail_sum_ff + SUM_W'(sample_ff);
            tail_sq_ff  <= tail_sq_ff + SQ_W'(sample_sq);
         end
      end else if (cmd.var_sel) begin
         head_sum_ff <= '0;
         head_sq_ff  <= '0;
         tail_sum_ff <= '0;
         tail_sq_ff  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff   <= SAMPLE_BITS'(req_sample);
         bin_addr_ff <= ADDR_W'(req_bin);
         bin_ok_ff   <= BIN_EXT'(req_bin) < BIN_EXT'(WAVE_MAX);
      end
   end

   // Scaled variance is BASE_LEN * square_sum - sum * sum, floored at zero.
   assign tail_pick = !(head_var_ff < tail_var_ff);

   always_ff @(posedge clock) begin
      if (cmd.var_mul) begin
         head_a_ff <= PROD_W'(head_sq_ff) * PROD_W'(BASE_LEN);
         head_b_ff <= PROD_W'(head_sum_ff) * PROD_W'(head_sum_ff);
         tail_a_ff <= PROD_W'(tail_sq_ff) * PROD_W'(BASE_LEN);
         tail_b_ff <= PROD_W'(tail_sum_ff) * PROD_W'(tail_sum_ff);
      end
      if (cmd.var_sub) begin
         head_var_ff <= (head_a_ff > head_b_ff) ? head_a_ff - head_b_ff : '0;
         tail_var_ff <= (tail_a_ff > tail_b_ff) ? tail_a_ff - tail_b_ff : '0;
      end
      if (cmd.var_sel) begin
         used_tail_ff <= tail_pick;
         wsum_ff      <= tail_pick ? tail_sum_ff : head_sum_ff;
         wvar_ff      <= tail_pick ? tail_var_ff : head_var_ff;
      end
   end

   // One sweep counter serves both the clearing pass and the accumulate pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= cmd.accum_step;
         if (cmd.clear_step || cmd.accum_step) begin
            sweep_ff <= sweep_last ? ADDR_W'(0) : sweep_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= sweep_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_update) begin
         buf_mem_ff[pos_ff[ADDR_W-1:0]] <= sample_ff;
      end
      buf_rd_ff <= buf_mem_ff[sweep_ff];
   end

   assign scaled    = SCL_W'(buf_rd_ff) * SCL_W'(BASE_LEN);
   assign acc_sum   = acc_rd_ff + ACC_W'(scaled) - ACC_W'(wsum_ff);
   assign acc_we    = cmd.clear_step || pend_ff;
   assign acc_waddr = cmd.clear_step ? sweep_ff : pend_addr_ff;
   assign acc_wdata = cmd.clear_step ? ACC_W'(0) : acc_sum;
   assign acc_raddr = cmd.accum_step ? sweep_ff : bin_addr_ff;

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem_ff[acc_waddr] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem_ff[acc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_step) begin
         waves_ff <= '0;
      end else if (cmd.count_bump) begin
         waves_ff <= waves_ff + bspa_pkg::COUNT_W'(1);
      end
   end

   assign bsum_ext = BS_EXT'(wsum_ff);
   assign var_ext  = VR_EXT'(wvar_ff);
   assign bsum_sat = (bsum_ext > BS_EXT'(bspa_pkg::BSUM_MAX)) ?
                     bspa_pkg::BSUM_MAX : bspa_pkg::BSUM_W'(bsum_ext);
   assign var_sat  = (var_ext > VR_EXT'(bspa_pkg::VAR_MAX)) ?
                     bspa_pkg::VAR_MAX : bspa_pkg::VAR_W'(var_ext);
   assign bin_sum  = bin_ok_ff ? acc_rd_ff[bspa_pkg::BINSUM_W-1:0] : bspa_pkg::BINSUM_W'(0);

   assign report_data = {bspa_pkg::RSP_PAD_W'(0), waves_ff, bspa_pkg::BINSUM_W'(0),
                         var_sat, used_tail_ff, bsum_sat};
   assign read_data   = {bspa_pkg::RSP_PAD_W'(0), waves_ff, bin_sum,
                         bspa_pkg::VAR_W'(0), 1'b0, bspa_pkg::BSUM_W'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_report || cmd.load_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_report) begin
         rsp_data_ff <= report_data;
         rsp_user_ff <= bspa_pkg::RKIND_REPORT;
      end else if (cmd.load_read) begin
         rsp_data_ff <= read_data;
         rsp_user_ff <= bspa_pkg::RKIND_READ;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_pend_after_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd.accum_step))
      else $error("accumulate write without a preceding read");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_report || cmd.load_read) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before its beat was taken");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < eff_len_ff)
      else $error("sample position past the waveform length");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_step && pend_ff))
      else $error("clearing pass and accumulate pass share the write port");

endmodule

// ===== design/baseline_subtracted_pulse_averager.sv =====
// Top level of the baseline-subtracted pulse averager. Sample beats are buffered until a
// waveform of the configured length (clamped to BASE_LEN..WAVE_MAX) is complete, while the
// sum and sum of squares of the head and tail windows are kept; the window with the smaller
// scaled variance gives the baseline (a tie picks the tail), a report beat carries its sum
// and variance, and BASE_LEN*sample minus the window sum is added into each bin. After the
// last sample of a waveform, the variance multiply, subtract and select steps run, then a
// sweep through the waveform's bins over the accumulator memory's read and write port and a
// drain step, then the report (once the count has saturated, the sweep and its drain are
// skipped). A read beat goes through the accumulator read port. After reset and after every
// clear beat, a clearing pass zeroes the whole accumulator while no request is accepted;
// configuration writes are always taken. A result beat waiting in the output register does
// not stop sample beats from being taken.
`timescale 1ns / 1ps

module baseline_subtracted_pulse_averager #(
   parameter int BASE_LEN    = 512,
   parameter int WAVE_MAX    = 4096,
   parameter int SAMPLE_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample_value [13:0], bin_index [25:14], zero fill [31:26]
   input  logic [bspa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [1:0]
   input  logic [bspa_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // baseline_sum [22:0], used_tail [23], scaled_variance [67:24], bin_sum [107:68],
   // wave_count [123:108], zero fill [127:124]
   output logic [bspa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // result_kind [0]
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bspa_pkg::LEN_CFG_W-1:0]    csr_wdata
);

   bspa_pkg::cmd_type    cmd;
   bspa_pkg::status_type status;

   assign csr_ready = 1'b1;

   bspa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   bspa_datapath #(
      .BASE_LEN    (BASE_LEN),
      .WAVE_MAX    (WAVE_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_tdata[bspa_pkg::SAMPLE_W-1:0]),
      .req_bin    (req_tdata[bspa_pkg::SAMPLE_W +: bspa_pkg::BIN_W]),
      .csr_write  (csr_valid && csr_ready),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
